FILE: rtl/tkst_pkg.sv
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types, codes and helper functions for the typed key set table.
// ----------------------------------------------------------------------------
package tkst_pkg;

    // default number of table slots
    localparam int TABLE_DEPTH_DEF = 64;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADTYPE = 2'd3;

    // key type tags
    localparam logic [3:0] TYPE_CHAR   = 4'd0;
    localparam logic [3:0] TYPE_UCHAR  = 4'd1;
    localparam logic [3:0] TYPE_SHORT  = 4'd2;
    localparam logic [3:0] TYPE_USHORT = 4'd3;
    localparam logic [3:0] TYPE_INT    = 4'd4;
    localparam logic [3:0] TYPE_UINT   = 4'd5;
    localparam logic [3:0] TYPE_LONG   = 4'd6;
    localparam logic [3:0] TYPE_ULONG  = 4'd7;
    localparam logic [3:0] TYPE_LLONG  = 4'd8;
    localparam logic [3:0] TYPE_ULLONG = 4'd9;
    localparam logic [3:0] TYPE_FLOAT  = 4'd10;
    localparam logic [3:0] TYPE_DOUBLE = 4'd11;
    localparam logic [3:0] TYPE_LIMIT  = 4'd12;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

    // one table slot as held in the slot memory
    typedef struct packed {
        logic        valid;
        logic [3:0]  ktype;
        logic [63:0] value;
    } slot_entry_t;

    // value bits that count for a type tag
    function automatic logic [63:0] type_mask(input logic [3:0] kt);
        case (kt) inside
            TYPE_CHAR, TYPE_UCHAR:              return 64'h0000_0000_0000_00FF;
            TYPE_SHORT, TYPE_USHORT:            return 64'h0000_0000_0000_FFFF;
            TYPE_INT, TYPE_UINT, TYPE_FLOAT:    return 64'h0000_0000_FFFF_FFFF;
            TYPE_LONG, TYPE_ULONG, TYPE_LLONG,
            TYPE_ULLONG, TYPE_DOUBLE:           return 64'hFFFF_FFFF_FFFF_FFFF;
            default:                            return 64'h0;
        endcase
    endfunction

    function automatic logic type_supported(input logic [3:0] kt);
        return kt < TYPE_LIMIT;
    endfunction

endpackage

FILE: rtl/typed_key_set_table_unit.sv
// ----------------------------------------------------------------------------
// typed_key_set_table_unit
// Bounded set of typed keys with add, delete and membership query.
// ----------------------------------------------------------------------------
// channel   signals                                      direction
// cmd       cmd_valid cmd_ready command key_type key_value  into block
// res       res_valid res_ready status found key_count      out of block
//
// Each item is taken in the idle state, then the scan makes one read of the slot
// memory per slot through the shared comparator, with registered read data, then
// the finish state updates the table and loads the result register.
// After reset a clearing pass writes every slot empty before the first item.
// An item whose key type is unsupported skips the scan and goes straight to the finish state.
// A result waiting on res_ready holds the block before the table update.
// ----------------------------------------------------------------------------
module typed_key_set_table_unit #(
    parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  command,
    input  logic [3:0]  key_type,
    input  logic [63:0] key_value,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [6:0]  key_count
);
    import tkst_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    seq_state_t state_reg, state_next;

    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [3:0]       type_reg, type_next;
    logic [63:0]      key_reg, key_next;
    logic             bad_type_reg, bad_type_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_valid_reg, res_valid_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_entry_t      mem_wr_data;
    logic             mem_rd_en;
    slot_entry_t      mem_rd_data;
    logic             slot_match;

    logic             out_free;
    logic [1:0]       fin_status;
    logic             fin_add;
    logic             fin_del;
    logic [CNT_W-1:0] count_after;

    // slot storage
    tkst_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

    // shared comparator, one slot per cycle
    tkst_key_match u_key_match (
        .entry       (mem_rd_data),
        .probe_type  (type_reg),
        .probe_value (key_reg),
        .match       (slot_match)
    );

    assign out_free = !res_valid_reg || res_ready;

    // outcome of the scan
    always_comb
    begin
        fin_status = ST_DONE;
        fin_add    = 1'b0;
        fin_del    = 1'b0;
        if (bad_type_reg)
        begin
            fin_status = ST_BADTYPE;
        end
        else
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (hit_found_reg)
                    begin
                        fin_status = ST_MISS;
                    end
                    else if (!free_found_reg)
                    begin
                        fin_status = ST_FULL;
                    end
                    else
                    begin
                        fin_add = 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (hit_found_reg)
                    begin
                        fin_del = 1'b1;
                    end
                    else
                    begin
                        fin_status = ST_MISS;
                    end
                end
                default:
                begin
                    fin_status = ST_DONE;
                end
            endcase
        end
        if (fin_add)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (fin_del)
        begin
            count_after = count_reg - CNT_W'(1);
        end
        else
        begin
            count_after = count_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = type_supported(key_type) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (rd_valid_reg && (rd_idx_reg == LAST_IDX))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_SCAN:
            begin
                mem_rd_en = !issue_done_reg;
            end
            ST_FINISH:
            begin
                mem_wr_en         = out_free && (fin_add || fin_del);
                mem_wr_addr       = fin_add ? free_idx_reg : hit_idx_reg;
                mem_wr_data.valid = fin_add;
                mem_wr_data.ktype = type_reg;
                mem_wr_data.value = key_reg;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = mem_rd_en;
        rd_idx_next     = addr_reg;
        cmd_next        = cmd_reg;
        type_next       = type_reg;
        key_next        = key_reg;
        bad_type_next   = bad_type_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_count_next  = res_count_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next        = command;
                    type_next       = key_type;
                    key_next        = key_value & type_mask(key_type);
                    bad_type_next   = !type_supported(key_type);
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // issue one slot read per cycle
                if (!issue_done_reg)
                begin
                    if (addr_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + IDX_W'(1);
                    end
                end
                // first equal key and first free slot
                if (rd_valid_reg)
                begin
                    if (mem_rd_data.valid && slot_match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                    end
                    if (!mem_rd_data.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    count_next      = count_after;
                    res_valid_next  = 1'b1;
                    res_status_next = fin_status;
                    res_found_next  = !bad_type_reg && hit_found_reg;
                    res_count_next  = count_after;
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        cmd_reg        <= cmd_next;
        type_reg       <= type_next;
        key_reg        <= key_next;
        bad_type_reg   <= bad_type_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_count_reg  <= res_count_next;
    end

    // result ports
    assign res_valid = res_valid_reg;
    assign status    = res_status_reg;
    assign found     = res_found_reg;

    generate
        if (CNT_W >= 7)
        begin : g_count_trunc
            assign key_count = res_count_reg[6:0];
        end
        else
        begin : g_count_ext
            assign key_count = {{(7 - CNT_W){1'b0}}, res_count_reg};
        end
    endgenerate

endmodule

FILE: rtl/tkst_slot_mem.sv
// ----------------------------------------------------------------------------
// tkst_slot_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tkst_slot_mem #(
    parameter int DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  tkst_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output tkst_pkg::slot_entry_t rd_data
);
    import tkst_pkg::*;

    slot_entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/tkst_key_match.sv
// ----------------------------------------------------------------------------
// tkst_key_match
// Shared key comparator: tag match plus bit or IEEE equality of the value.
// ----------------------------------------------------------------------------
module tkst_key_match (
    input  tkst_pkg::slot_entry_t entry,
    input  logic [3:0]            probe_type,
    input  logic [63:0]           probe_value,
    output logic                  match
);
    import tkst_pkg::*;

    logic is_float;
    logic is_double;
    logic nan_a;
    logic nan_b;
    logic zero_a;
    logic zero_b;
    logic bits_eq;

    // nan and signed-zero detection for both operands
    always_comb
    begin
        is_float  = (probe_type == TYPE_FLOAT);
        is_double = (probe_type == TYPE_DOUBLE);
        if (is_double)
        begin
            nan_a  = (entry.value[62:52] == 11'h7FF) && (entry.value[51:0] != 52'h0);
            nan_b  = (probe_value[62:52] == 11'h7FF) && (probe_value[51:0] != 52'h0);
            zero_a = (entry.value[62:0] == 63'h0);
            zero_b = (probe_value[62:0] == 63'h0);
        end
        else
        begin
            nan_a  = (entry.value[30:23] == 8'hFF) && (entry.value[22:0] != 23'h0);
            nan_b  = (probe_value[30:23] == 8'hFF) && (probe_value[22:0] != 23'h0);
            zero_a = (entry.value[30:0] == 31'h0);
            zero_b = (probe_value[30:0] == 31'h0);
        end
    end

    // final equality
    always_comb
    begin
        bits_eq = (entry.value == probe_value);
        if (entry.ktype != probe_type)
        begin
            match = 1'b0;
        end
        else if (is_float || is_double)
        begin
            match = !nan_a && !nan_b && ((zero_a && zero_b) || bits_eq);
        end
        else
        begin
            match = bits_eq;
        end
    end

endmodule
